// ===== hdl/loop_period_averager_assert.svh =====
// ----------------------------------------------------------------------------
// loop period averager assertion macros
// shared immediate-to-property wrappers for the checker, clocked on clk
// and disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef LOOP_PERIOD_AVERAGER_ASSERT_SVH
`define LOOP_PERIOD_AVERAGER_ASSERT_SVH

// same-cycle implication
`define LPA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LPA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/lpa_pkg.sv =====
// ----------------------------------------------------------------------------
// loop period averager package
// widths, constants and shared types of the loop period averager
// ----------------------------------------------------------------------------
package lpa_pkg;

	localparam int SAMPLE_COUNT  = 16;
	localparam int US_PER_SECOND = 1000000;

	localparam int TS_W       = 64;
	localparam int DELTA_W    = 32;
	localparam int RATE_W     = 20;
	localparam int DIVR_W     = 32;
	// sample count is a power of two, the mean is the total shifted down
	localparam int MEAN_SHIFT = $clog2(SAMPLE_COUNT);
	localparam int TOTAL_W    = DELTA_W + MEAN_SHIFT;
	localparam int IDX_W      = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
	localparam int CNT_W      = $clog2(RATE_W);

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);

	typedef logic [TOTAL_W-1:0] total_t;

	typedef struct packed {
		logic full;
		logic empty;
	} lpa_qstat_t;

endpackage

// ===== hdl/lpa_front.sv =====
// ----------------------------------------------------------------------------
// loop period averager front end
// accepts timestamps, forms saturated deltas and keeps the delta ring and
// its running total; each new total goes to the queue
// ----------------------------------------------------------------------------
module lpa_front
	import lpa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [TS_W-1:0]   timestamp_us,
	output logic              full,
	input  lpa_qstat_t        qstat,
	output logic              q_push,
	output total_t            q_total
);

	logic [TS_W-1:0]    prev_q;
	logic               seen_q;
	logic               v_s1;
	logic [DELTA_W-1:0] delta_s1;
	logic [DELTA_W-1:0] ring_q [SAMPLE_COUNT];
	logic [IDX_W-1:0]   idx_q;
	logic               filled_q;
	total_t             total_q;

	logic [TS_W-1:0]    diff;
	logic [DELTA_W-1:0] sat;
	logic [DELTA_W-1:0] old;
	total_t             total_next;
	logic               accept;
	logic               commit;

	assign commit = v_s1 & ~qstat.full;
	assign full   = v_s1 & qstat.full;
	assign accept = push & ~full;

	assign diff = timestamp_us - prev_q;
	assign sat  = (|diff[TS_W-1:DELTA_W]) ? '1 : diff[DELTA_W-1:0];

	// entries not yet written since reset read as zero
	assign old        = filled_q ? ring_q[idx_q] : '0;
	assign total_next = total_q - TOTAL_W'(old) + TOTAL_W'(delta_s1);

	assign q_push  = commit;
	assign q_total = total_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= '0;
			seen_q   <= 1'b0;
			v_s1     <= 1'b0;
			idx_q    <= '0;
			filled_q <= 1'b0;
			total_q  <= '0;
		end else begin
			if (accept) begin
				prev_q <= timestamp_us;
				seen_q <= 1'b1;
				v_s1   <= 1'b1;
			end else if (commit) begin
				v_s1 <= 1'b0;
			end
			if (commit) begin
				total_q <= total_next;
				if (idx_q == IDX_W'(SAMPLE_COUNT - 1)) begin
					idx_q    <= '0;
					filled_q <= 1'b1;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			delta_s1 <= seen_q ? sat : '0;
		end
		if (commit) begin
			ring_q[idx_q] <= delta_s1;
		end
	end

endmodule

// ===== hdl/lpa_fifo.sv =====
// ----------------------------------------------------------------------------
// loop period averager queue
// short queue of ring totals between the front end and the divider
// ----------------------------------------------------------------------------
module lpa_fifo
	import lpa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr,
	input  total_t     wr_data,
	input  logic       rd,
	output total_t     rd_data,
	output lpa_qstat_t stat
);

	total_t           mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             wr_ok;
	logic             rd_ok;

	assign stat.full  = (count_q == (PTR_W + 1)'(FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign wr_ok      = wr & ~stat.full;
	assign rd_ok      = rd & ~stat.empty;
	assign rd_data    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_ok) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_ok) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr_ok, rd_ok})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== hdl/lpa_back.sv =====
// ----------------------------------------------------------------------------
// loop period averager back end
// the mean is the ring total shifted down by the sample count bits, then a
// serial restoring divider gives 1000000 / mean as the rate; results wait
// in an output register
// ----------------------------------------------------------------------------
module lpa_back
	import lpa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  lpa_qstat_t         qstat,
	input  total_t             q_data,
	output logic               q_pop,
	input  logic               pop,
	output logic               empty,
	output logic [DELTA_W-1:0] average_period_us,
	output logic [RATE_W-1:0]  loop_rate_hz,
	output logic               zero_period
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RATE = 3'b010,
		ST_DONE = 3'b100
	} back_state_t;

	back_state_t        state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [RATE_W-1:0]  dvd_q;
	logic [DIVR_W-1:0]  rem_q;
	logic [DIVR_W-1:0]  divr_q;
	logic [DELTA_W-1:0] mean_q;
	logic               out_v_q;

	logic [DELTA_W-1:0] mean;
	logic [DIVR_W:0]    rem_sh;
	logic [DIVR_W:0]    rem_sub;
	logic               ge;
	logic [DIVR_W-1:0]  rem_step;
	logic [RATE_W-1:0]  dvd_step;
	logic               out_free;

	assign mean     = DELTA_W'(q_data >> MEAN_SHIFT);

	assign rem_sh   = {rem_q, dvd_q[RATE_W-1]};
	assign rem_sub  = rem_sh - {1'b0, divr_q};
	assign ge       = (rem_sh >= {1'b0, divr_q});
	assign rem_step = ge ? rem_sub[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
	assign dvd_step = {dvd_q[RATE_W-2:0], ge};

	assign empty    = ~out_v_q;
	assign out_free = ~out_v_q | pop;
	assign q_pop    = (state_q == ST_IDLE) & ~qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!qstat.empty) begin
						state_q <= ST_RATE;
						cnt_q   <= CNT_W'(RATE_W - 1);
					end
				end
				ST_RATE: begin
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if ((state_q == ST_DONE) && out_free) begin
				out_v_q <= 1'b1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				mean_q <= mean;
				divr_q <= DIVR_W'(mean);
				dvd_q  <= RATE_W'(US_PER_SECOND);
				rem_q  <= '0;
			end
			ST_RATE: begin
				dvd_q <= dvd_step;
				rem_q <= rem_step;
			end
			ST_DONE: begin
				if (out_free) begin
					average_period_us <= mean_q;
					zero_period       <= (mean_q == '0);
					loop_rate_hz      <= (mean_q == '0) ? '0 : dvd_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hdl/loop_period_averager.sv =====
// ----------------------------------------------------------------------------
// loop period averager
// moving average of the last SAMPLE_COUNT loop periods (timestamp deltas) and
// the matching loop rate in loops per second
// ----------------------------------------------------------------------------
// the back end works on one total at a time: it takes the total off the queue,
// runs 20 restoring steps for the rate and hands the result to the output
// register once that is free, and only then takes the next total off the queue
// the mean is a shift of the ring total and costs no divider steps
// the front end takes a new timestamp every cycle until the 4-deep queue fills
// reset: asynchronous, clears the ring (reads as zero until written) and queues
module loop_period_averager
	import lpa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [TS_W-1:0]    timestamp_us,
	output logic               empty,
	input  logic               pop,
	output logic [DELTA_W-1:0] average_period_us,
	output logic [RATE_W-1:0]  loop_rate_hz,
	output logic               zero_period
);

	lpa_qstat_t qstat;
	logic       q_push;
	logic       q_pop;
	total_t     q_total;
	total_t     q_data;

	lpa_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.timestamp_us (timestamp_us),
		.full         (full),
		.qstat        (qstat),
		.q_push       (q_push),
		.q_total      (q_total)
	);

	lpa_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_push),
		.wr_data (q_total),
		.rd      (q_pop),
		.rd_data (q_data),
		.stat    (qstat)
	);

	lpa_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.qstat             (qstat),
		.q_data            (q_data),
		.q_pop             (q_pop),
		.pop               (pop),
		.empty             (empty),
		.average_period_us (average_period_us),
		.loop_rate_hz      (loop_rate_hz),
		.zero_period       (zero_period)
	);

endmodule

// ===== hdl/lpa_checker.sv =====
// ----------------------------------------------------------------------------
// loop period averager checker
// port-level properties of the result side, bound to the top level
// ----------------------------------------------------------------------------
`include "loop_period_averager_assert.svh"

module lpa_checker
	import lpa_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input logic [DELTA_W-1:0] average_period_us,
	input logic [RATE_W-1:0]  loop_rate_hz,
	input logic               zero_period
);

	localparam logic [RATE_W-1:0] TOP_RATE = RATE_W'(US_PER_SECOND);

	logic                      shown;
	logic                      mean_zero;
	logic                      mean_unit;
	logic [DELTA_W+RATE_W:0]   shown_data;

	assign shown      = ~empty;
	assign mean_zero  = (average_period_us == '0);
	assign mean_unit  = (average_period_us == DELTA_W'(1));
	assign shown_data = {average_period_us, loop_rate_hz, zero_period};

	`LPA_ASSERT_IMP(a_zero_flag, shown, zero_period == mean_zero, "zero flag disagrees with mean")
	`LPA_ASSERT_IMP(a_zero_rate, shown && zero_period, loop_rate_hz == '0, "rate not zero")
	`LPA_ASSERT_IMP(a_unit_period, shown && mean_unit, loop_rate_hz == TOP_RATE, "bad unit rate")
	`LPA_ASSERT_NXT(a_hold, shown && !pop, shown && $stable(shown_data), "stalled transaction changed")

endmodule

bind loop_period_averager lpa_checker u_lpa_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.empty             (empty),
	.pop               (pop),
	.average_period_us (average_period_us),
	.loop_rate_hz      (loop_rate_hz),
	.zero_period       (zero_period)
);

// ===== tb/loop_period_averager_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// loop period averager testbench
// drives timestamp transactions through the input queue and checks every
// result transaction against a local model of the 16-entry delta ring, the
// truncated mean and the loop rate; a directed table of extremes and corner
// cases is followed by random bursts of steady, tiny, frozen, saturating,
// wrapping and noisy timestamps, with random idling on both sides and one
// long receiver hold-off that fills the block
// ----------------------------------------------------------------------------
module loop_period_averager_tb;
	import lpa_pkg::*;

	localparam int RANDOM_ITEMS = 1530;
	localparam int DIR_ROWS     = 22;
	localparam int HOLD_AT      = 200;
	localparam int HOLD_CYCLES  = 800;
	localparam int DRAIN_CYCLES = 100;
	localparam int CYCLE_LIMIT  = 500000;

	typedef struct packed {
		logic [DELTA_W-1:0] avg;
		logic [RATE_W-1:0]  rate;
		logic               zero;
	} period_result_t;

	typedef struct packed {
		logic [TS_W-1:0] ts;
		logic            typed;
		period_result_t  res;
	} stim_row_t;

	typedef enum int {
		BURST_STEADY,
		BURST_TINY,
		BURST_STILL,
		BURST_LONG_GAP,
		BURST_JUMP,
		BURST_NOISE
	} burst_kind_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [TS_W-1:0]    timestamp_us;
	logic               empty;
	logic               pop;
	logic [DELTA_W-1:0] average_period_us;
	logic [RATE_W-1:0]  loop_rate_hz;
	logic               zero_period;

	// local copy of the meter state
	logic [TS_W-1:0]    last_ts;
	logic               seen_ts;
	logic [DELTA_W-1:0] delta_hist [SAMPLE_COUNT];
	logic [63:0]        delta_sum;
	int                 hist_idx;

	period_result_t expected_periods [$];
	stim_row_t      dir_rows [DIR_ROWS];

	int  error_count     = 0;
	int  items_sent      = 0;
	int  results_seen    = 0;
	int  zero_results    = 0;
	int  stall_cycles    = 0;
	int  cycle_count     = 0;
	logic send_burst_nogap = 1'b0;

	loop_period_averager u_top (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.timestamp_us      (timestamp_us),
		.empty             (empty),
		.pop               (pop),
		.average_period_us (average_period_us),
		.loop_rate_hz      (loop_rate_hz),
		.zero_period       (zero_period)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (push && full)
			stall_cycles++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic period_result_t advance_period_meter(input logic [TS_W-1:0] ts);
		logic [TS_W-1:0]    diff;
		logic [DELTA_W-1:0] delta;
		logic [63:0]        mean;
		period_result_t     r;
		diff = seen_ts ? ts - last_ts : '0;
		delta = (diff > 64'hFFFF_FFFF) ? '1 : diff[DELTA_W-1:0];
		last_ts = ts;
		seen_ts = 1'b1;
		delta_sum = delta_sum - 64'(delta_hist[hist_idx]) + 64'(delta);
		delta_hist[hist_idx] = delta;
		hist_idx = (hist_idx == SAMPLE_COUNT - 1) ? 0 : hist_idx + 1;
		mean = delta_sum / SAMPLE_COUNT;
		r.avg  = mean[DELTA_W-1:0];
		r.zero = (mean == 0);
		r.rate = (mean == 0) ? '0 : RATE_W'(64'(US_PER_SECOND) / mean);
		return r;
	endfunction

	function automatic stim_row_t stim_row(input logic [TS_W-1:0] ts, input logic typed,
			input logic [DELTA_W-1:0] avg, input logic [RATE_W-1:0] rate,
			input logic zero);
		stim_row_t row;
		row.ts       = ts;
		row.typed    = typed;
		row.res.avg  = avg;
		row.res.rate = rate;
		row.res.zero = zero;
		return row;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch at result %0d: %s got %0h expected %0h",
			results_seen, what, got, want);
		error_count++;
	endtask

	task automatic send_timestamp(input logic [TS_W-1:0] ts, input logic typed,
			input period_result_t typed_res);
		int             gap;
		period_result_t pred;
		gap = send_burst_nogap ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push         <= 1'b1;
		timestamp_us <= ts;
		do @(posedge clk); while (full);
		pred = advance_period_meter(ts);
		expected_periods.push_back(typed ? typed_res : pred);
		items_sent++;
	endtask

	// result side
	initial begin : result_drain
		int             wait_cycles;
		int             zero_run;
		logic           hold_done;
		period_result_t want;
		pop = 1'b0;
		zero_run  = 0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			if (results_seen == HOLD_AT && !hold_done) begin
				hold_done   = 1'b1;
				wait_cycles = HOLD_CYCLES;
			end else if (zero_run > 0) begin
				zero_run--;
				wait_cycles = 0;
			end else if ($urandom_range(0, 15) == 0) begin
				zero_run    = $urandom_range(10, 40);
				wait_cycles = 0;
			end else begin
				wait_cycles = $urandom_range(0, 9);
			end
			if (wait_cycles > 0) begin
				pop <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			if (expected_periods.size() == 0) begin
				report_mismatch("transaction with nothing expected", average_period_us, 0);
			end else begin
				want = expected_periods.pop_front();
				if (average_period_us !== want.avg)
					report_mismatch("average_period_us", average_period_us, want.avg);
				if (loop_rate_hz !== want.rate)
					report_mismatch("loop_rate_hz", loop_rate_hz, want.rate);
				if (zero_period !== want.zero)
					report_mismatch("zero_period", zero_period, want.zero);
			end
			if (zero_period === 1'b1)
				zero_results++;
			results_seen++;
		end
	end

	// input side
	initial begin : stimulus
		logic [TS_W-1:0] cur_ts;
		burst_kind_t     kind;
		int unsigned     base;
		int              pick;
		int              burst;
		push         = 1'b0;
		timestamp_us = '0;
		arst_n       = 1'b0;
		last_ts      = '0;
		seen_ts      = 1'b0;
		delta_sum    = '0;
		hist_idx     = 0;
		for (int i = 0; i < SAMPLE_COUNT; i++)
			delta_hist[i] = '0;

		// first timestamp is all ones, delta zero
		dir_rows[0] = stim_row('1, 1'b1, '0, '0, 1'b1);
		// backwards by wrap gives a delta of one, mean still zero
		dir_rows[1] = stim_row(64'd0, 1'b1, '0, '0, 1'b1);
		// delta of 2^32 saturates, ring total becomes 2^32
		dir_rows[2] = stim_row(64'h0000_0001_0000_0000, 1'b1, 32'h1000_0000, '0, 1'b0);
		dir_rows[3] = stim_row(64'h8000_0000_0000_0000, 1'b0, '0, '0, 1'b0);
		// going backwards, saturated
		dir_rows[4] = stim_row(64'd5, 1'b0, '0, '0, 1'b0);
		// sixteen deltas of one fill the ring: mean one, top rate
		for (int k = 0; k < SAMPLE_COUNT; k++)
			dir_rows[5 + k] = stim_row(64'd6 + k, k == SAMPLE_COUNT - 1, 32'd1,
				RATE_W'(US_PER_SECOND), 1'b0);
		dir_rows[21] = stim_row('1, 1'b0, '0, '0, 1'b0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++)
			send_timestamp(dir_rows[i].ts, dir_rows[i].typed, dir_rows[i].res);

		cur_ts = {$urandom, $urandom};
		while (items_sent < DIR_ROWS + RANDOM_ITEMS) begin
			pick = $urandom_range(0, 19);
			if (pick < 8)
				kind = BURST_STEADY;
			else if (pick < 11)
				kind = BURST_TINY;
			else if (pick < 13)
				kind = BURST_STILL;
			else if (pick < 15)
				kind = BURST_LONG_GAP;
			else if (pick < 17)
				kind = BURST_JUMP;
			else
				kind = BURST_NOISE;
			burst = (kind == BURST_STILL) ? $urandom_range(17, 30) : $urandom_range(8, 40);
			send_burst_nogap = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 2))
				0: base = $urandom_range(1, 100);
				1: base = $urandom_range(100, 10000);
				default: base = $urandom_range(10000, 2000000);
			endcase
			for (int k = 0; k < burst; k++) begin
				case (kind)
					BURST_STEADY: begin
						cur_ts += 64'(base) + 64'($urandom_range(0, base / 8));
					end
					BURST_TINY: begin
						cur_ts += 64'($urandom_range(0, 3));
					end
					BURST_STILL: begin
					end
					BURST_LONG_GAP: begin
						case ($urandom_range(0, 2))
							0: cur_ts += 64'($urandom);
							1: cur_ts += 64'h1_0000_0000 + 64'($urandom);
							default: cur_ts += 64'hFFFF_FFFF;
						endcase
					end
					BURST_JUMP: begin
						if (k == 0)
							cur_ts = $urandom_range(0, 1) ? {$urandom, $urandom} :
								64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 5000));
						cur_ts += 64'($urandom_range(1, 2000));
					end
					default: begin
						cur_ts = {$urandom, $urandom};
					end
				endcase
				send_timestamp(cur_ts, 1'b0, '0);
			end
		end
		push <= 1'b0;

		while (expected_periods.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d timestamp transactions sent, %0d results checked, %0d with zero mean",
			items_sent, results_seen, zero_results);
		$display("input held off by a full queue for %0d cycles", stall_cycles);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches", error_count);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== loop_period_averager.f =====
+incdir+hdl
hdl/lpa_pkg.sv
hdl/lpa_front.sv
hdl/lpa_fifo.sv
hdl/lpa_back.sv
hdl/loop_period_averager.sv
hdl/lpa_checker.sv
tb/loop_period_averager_tb.sv
